>>> src/jtdd_pkg.sv
`default_nettype none
package jtdd_pkg;

    localparam logic [1:0] CMD_JOY    = 2'd0;
    localparam logic [1:0] CMD_BUTTON = 2'd1;

    localparam logic [7:0] BTN_REMOTE_OFF = 8'h46;
    localparam logic [7:0] BTN_REMOTE_ON  = 8'h47;
    localparam logic [7:0] BTN_NITRO_ON   = 8'h43;
    localparam logic [7:0] BTN_NITRO_OFF  = 8'h4A;

    localparam int SPEED_W = 14;
    localparam int LEVEL_W = 5;

    typedef logic signed [LEVEL_W-1:0] t_level;

    typedef struct packed {
        logic   handled;
        logic   drive_valid;
        logic   nitro;
        t_level speed_lvl;
        t_level dir_lvl;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    // Axis scaled to -10..10 steps of 100: positive values divide by 127,
    // the rest by 128, both truncated toward zero.
    function automatic t_level scale_axis(input logic signed [7:0] v);
        logic [7:0]  mag;
        logic [10:0] n;
        logic [3:0]  q0;
        logic [10:0] rem;
        logic [3:0]  q;
        begin
            if (v > 8'sd0) begin
                mag = v;
                n   = 11'(mag) * 11'd10;
                q0  = 4'(n >> 7);
                rem = n - ((11'(q0) << 7) - 11'(q0));
                q   = (rem >= 11'd127) ? q0 + 4'd1 : q0;
                scale_axis = LEVEL_W'($signed({1'b0, q}));
            end else begin
                mag = 8'(-$signed(9'(v)));
                n   = 11'(mag) * 11'd10;
                q   = 4'(n >> 7);
                scale_axis = -LEVEL_W'($signed({1'b0, q}));
            end
        end
    endfunction

endpackage
`default_nettype wire

>>> src/jtdd_front.sv
`default_nettype none
module jtdd_front
    import jtdd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_data,
    input  wire logic        i_accept,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_joy_x,
    input  wire logic [7:0]  i_joy_y,
    input  wire logic [7:0]  i_button_code,
    output t_push            o_push
);

    logic r_use_joystick;
    logic r_remote_on;
    logic r_nitro_on;
    logic n_remote_on;
    logic n_nitro_on;

    logic signed [7:0] x_dz;
    logic signed [7:0] y_dz;
    logic              is_joy;
    logic              is_button;
    logic              drive;

    always_comb begin
        x_dz = $signed(i_joy_x);
        y_dz = $signed(i_joy_y);
        if (x_dz > -8'sd5 && x_dz < 8'sd5) begin
            x_dz = 8'sd0;
        end
        if (y_dz > -8'sd15 && y_dz < 8'sd5) begin
            y_dz = 8'sd0;
        end
    end

    assign is_joy    = (i_cmd == CMD_JOY);
    assign is_button = (i_cmd == CMD_BUTTON);
    assign drive     = is_joy && r_use_joystick && r_remote_on;

    always_comb begin
        n_remote_on = r_remote_on;
        n_nitro_on  = r_nitro_on;
        if (i_accept && is_button) begin
            unique case (i_button_code)
                BTN_REMOTE_OFF: n_remote_on = 1'b0;
                BTN_REMOTE_ON:  n_remote_on = 1'b1;
                BTN_NITRO_ON:   n_nitro_on  = 1'b1;
                BTN_NITRO_OFF:  n_nitro_on  = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_joystick <= 1'b1;
            r_remote_on    <= 1'b1;
            r_nitro_on     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_use_joystick <= i_cfg_data;
            end
            r_remote_on <= n_remote_on;
            r_nitro_on  <= n_nitro_on;
        end
    end

    always_comb begin
        o_push.valid             = i_accept;
        o_push.entry.handled     = is_joy || is_button;
        o_push.entry.drive_valid = drive;
        o_push.entry.nitro       = r_nitro_on;
        o_push.entry.speed_lvl   = drive ? scale_axis(y_dz) : '0;
        o_push.entry.dir_lvl     = drive ? scale_axis(x_dz) : '0;
    end

endmodule
`default_nettype wire

>>> src/jtdd_queue.sv
`default_nettype none
module jtdd_queue
    import jtdd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    input  wire logic  i_pop,
    output logic       o_full,
    output t_head      o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry        r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full       = (r_count == CW'(DEPTH));
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/jtdd_back.sv
`default_nettype none
module jtdd_back
    import jtdd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_head               i_head,
    output logic                     o_pop,
    input  wire logic                i_ready,
    output logic                     o_valid,
    output logic                     o_handled,
    output logic                     o_drive_valid,
    output logic signed [SPEED_W-1:0] o_left,
    output logic signed [SPEED_W-1:0] o_right
);

    logic                      r_valid;
    logic                      r_handled;
    logic                      r_drive_valid;
    logic signed [SPEED_W-1:0] r_left;
    logic signed [SPEED_W-1:0] r_right;

    logic signed [7:0] s;
    logic signed [7:0] d;
    logic signed [7:0] b;
    logic signed [7:0] lu;
    logic signed [7:0] ru;
    logic signed [7:0] lk;
    logic signed [7:0] rk;
    logic              curve;
    logic              straight;
    logic              spin;
    logic signed [SPEED_W-1:0] n_left;
    logic signed [SPEED_W-1:0] n_right;

    // Work in steps of 100; the axis magnitudes map to these level tests.
    always_comb begin
        s        = 8'(i_head.entry.speed_lvl);
        d        = 8'(i_head.entry.dir_lvl);
        b        = s <<< 1;
        curve    = (d >= 8'sd4 || d <= -8'sd4) && (s >= 8'sd4 || s <= -8'sd4);
        straight = (s >= 8'sd2 || s <= -8'sd2);
        spin     = (d >= 8'sd2 || d <= -8'sd2);
        lu       = 8'sd0;
        ru       = 8'sd0;
        if (curve) begin
            if (d < 8'sd0) begin
                lu = b;
                ru = (b < 8'sd0) ? b + d : b - d;
            end else begin
                ru = b;
                lu = (b < 8'sd0) ? b - d : b + d;
            end
        end else if (straight) begin
            lu = s <<< 2;
            ru = s <<< 2;
        end else if (spin) begin
            lu = d;
            ru = -d;
        end
        if (i_head.entry.nitro) begin
            if (straight && !curve) begin
                lk = (s <<< 2) + (s <<< 1);
                rk = lk;
            end else begin
                lk = lu <<< 1;
                rk = ru <<< 1;
            end
        end else begin
            lk = lu;
            rk = ru;
        end
        if (i_head.entry.drive_valid) begin
            n_left  = SPEED_W'(lk) * SPEED_W'(100);
            n_right = SPEED_W'(rk) * SPEED_W'(100);
        end else begin
            n_left  = '0;
            n_right = '0;
        end
    end

    assign o_pop = i_head.valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_handled     <= i_head.entry.handled;
            r_drive_valid <= i_head.entry.drive_valid;
            r_left        <= n_left;
            r_right       <= n_right;
        end
    end

    assign o_valid       = r_valid;
    assign o_handled     = r_handled;
    assign o_drive_valid = r_drive_valid;
    assign o_left        = r_left;
    assign o_right       = r_right;

endmodule
`default_nettype wire

>>> src/joystick_to_differential_drive.sv
// Remote message handler that turns joystick samples into wheel speeds.
// Input channel (i_s_axis_*): one remote message per item. tuser holds the
// message type, tdata holds the joystick axes and the button code.
// Output channel (o_m_axis_*): exactly one result item per input item, in
// order. tuser carries the handled and drive_valid flags, tdata the left
// and right wheel speeds as signed values.
// Configuration channel (i_cfg_*): writes the use_joystick bit; it is
// always ready and should be written only while no items are in flight.
// An accepted item is written into the queue, then into the output
// register once the output is free, where its result can be taken.
// Throughput is one item per cycle while the receiver takes results;
// the front stage updates the remote and nitro state and scales the
// axes, the back stage mixes the speeds into its output register.
// A queue of QUEUE_DEPTH entries sits between the stages, so input stays
// ready while the receiver stalls until the queue fills.
// Reset sets use_joystick and remote on, clears nitro and empties the queue.
`default_nettype none
module joystick_to_differential_drive
    import jtdd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // Fields from bit 0: joy_x[7:0], joy_y[15:8], button_code[23:16].
    input  wire logic [23:0] i_s_axis_tdata,
    // Fields from bit 0: cmd[1:0].
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // Fields from bit 0: left_speed[13:0], right_speed[27:14], zeros above.
    output logic [31:0]      o_m_axis_tdata,
    // Fields from bit 0: handled[0], drive_valid[1].
    output logic [1:0]       o_m_axis_tuser
);

    t_push push;
    t_head head;
    logic  full;
    logic  pop;
    logic  accept;
    logic  handled;
    logic  drive_valid;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !full;
    assign accept          = i_s_axis_tvalid && !full;

    jtdd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_cmd         (i_s_axis_tuser),
        .i_joy_x       (i_s_axis_tdata[7:0]),
        .i_joy_y       (i_s_axis_tdata[15:8]),
        .i_button_code (i_s_axis_tdata[23:16]),
        .o_push        (push)
    );

    jtdd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    jtdd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_ready       (i_m_axis_tready),
        .o_valid       (o_m_axis_tvalid),
        .o_handled     (handled),
        .o_drive_valid (drive_valid),
        .o_left        (left_speed),
        .o_right       (right_speed)
    );

    assign o_m_axis_tdata = {4'b0000, right_speed, left_speed};
    assign o_m_axis_tuser = {drive_valid, handled};

endmodule
`default_nettype wire

>>> src/jtdd_checker.sv
`default_nettype none
module jtdd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser
);

    logic signed [13:0] left_speed;
    logic signed [13:0] right_speed;

    assign left_speed  = $signed(o_m_axis_tdata[13:0]);
    assign right_speed = $signed(o_m_axis_tdata[27:14]);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Output valid right after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("Output item changed while stalled.");

    a_drive_needs_handled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tuser[0])
        else $error("Speeds issued for an unhandled item.");

    a_idle_speeds_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[1] |-> o_m_axis_tdata == 32'd0)
        else $error("Nonzero speeds without drive_valid.");

    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            left_speed >= -14'sd6000 && left_speed <= 14'sd6000 &&
            right_speed >= -14'sd6000 && right_speed <= 14'sd6000 &&
            o_m_axis_tdata[31:28] == 4'b0000)
        else $error("Wheel speed out of range.");

endmodule

bind joystick_to_differential_drive jtdd_checker u_jtdd_checker (.*);
`default_nettype wire

>>> tb/joystick_to_differential_drive_test.sv
`default_nettype none
module joystick_to_differential_drive_test;
    import jtdd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_OTHER  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_IDLE  = 18;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic               handled;
        logic               drive_valid;
        logic signed [13:0] left_speed;
        logic signed [13:0] right_speed;
    } t_wheel_cmd;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         joy_x;
        logic [7:0]         joy_y;
        logic [7:0]         button;
        logic               fixed;
        logic               handled;
        logic               drive_valid;
        logic signed [13:0] left_speed;
        logic signed [13:0] right_speed;
    } t_stim_row;

    typedef struct {
        logic use_joy;
        int   count;
        bit   quiet;
        bit   hold;
    } t_phase;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    wire logic        cfg_ready;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [31:0] m_tdata;
    wire logic [1:0]  m_tuser;

    logic use_joystick = 1'b1;
    logic remote_on = 1'b1;
    logic nitro_on = 1'b0;
    t_wheel_cmd wheels_pending[$];
    int  mismatches = 0;
    bit  no_idle = 1'b0;
    bit  hold_request = 1'b0;

    joystick_to_differential_drive dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("joystick_to_differential_drive verification failed");
        $finish;
    end

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int axis_to_speed(input int v);
        int t;
        t = (v > 0) ? (v * 10) / 127 : (v * 10) / 128;
        t = t * 100;
        if (t < -1000) t = -1000;
        if (t > 1000) t = 1000;
        return t;
    endfunction

    function automatic t_wheel_cmd predict_wheels(input logic [1:0] cmd, input logic [7:0] jx,
                                                  input logic [7:0] jy, input logic [7:0] btn);
        t_wheel_cmd res;
        int x, y, s, d, b, k, lv, rv;
        res = '0;
        lv = 0;
        rv = 0;
        if (cmd == CMD_JOY) begin
            x = $signed(jx);
            y = $signed(jy);
            res.handled = 1'b1;
            if (x > -5 && x < 5) x = 0;
            if (y > -15 && y < 5) y = 0;
            if (use_joystick && remote_on) begin
                s = axis_to_speed(y);
                d = axis_to_speed(x);
                k = nitro_on ? 2 : 1;
                if (magnitude(d) > 350 && magnitude(s) > 350) begin
                    b = 2 * s;
                    if (d < 0) begin
                        lv = b;
                        rv = (b < 0) ? b + d : b - d;
                    end else begin
                        rv = b;
                        lv = (b < 0) ? b - d : b + d;
                    end
                    lv = lv * k;
                    rv = rv * k;
                end else if (magnitude(s) > 100) begin
                    lv = s * (nitro_on ? 6 : 4);
                    rv = lv;
                end else if (magnitude(d) > 110) begin
                    lv = d * k;
                    rv = -d * k;
                end
                res.drive_valid = 1'b1;
                res.left_speed  = lv[13:0];
                res.right_speed = rv[13:0];
            end
        end else if (cmd == CMD_BUTTON) begin
            res.handled = 1'b1;
            case (btn)
                BTN_REMOTE_OFF: remote_on = 1'b0;
                BTN_REMOTE_ON:  remote_on = 1'b1;
                BTN_NITRO_ON:   nitro_on = 1'b1;
                BTN_NITRO_OFF:  nitro_on = 1'b0;
                default: ;
            endcase
        end
        return res;
    endfunction

    function automatic int idle_cycles();
        return no_idle ? 0 : int'($urandom_range(0, MAX_IDLE));
    endfunction

    function automatic logic [7:0] rand_axis();
        logic [7:0] v;
        case ($urandom_range(0, 4))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 8'h80;
                    1: v = 8'h81;
                    2: v = 8'h7F;
                    default: v = 8'h7E;
                endcase
            end
            1: begin
                case ($urandom_range(0, 5))
                    0: v = -8'sd15;
                    1: v = -8'sd14;
                    2: v = -8'sd5;
                    3: v = -8'sd4;
                    4: v = 8'sd4;
                    default: v = 8'sd5;
                endcase
            end
            2: begin
                v = 8'($urandom_range(0, 60));
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    task automatic offer_msg(input logic [1:0] cmd, input logic [7:0] jx, input logic [7:0] jy,
                             input logic [7:0] btn, input logic fixed, input t_wheel_cmd fixed_res);
        t_wheel_cmd predicted;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {btn, jy, jx};
        s_tuser  <= cmd;
        do @(posedge clk); while (s_tready !== 1'b1);
        predicted = predict_wheels(cmd, jx, jy, btn);
        wheels_pending.push_back(fixed ? fixed_res : predicted);
        gap = idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic offer_random_msg();
        logic [1:0] cmd;
        logic [7:0] jx, jy, btn;
        int roll;
        roll = $urandom_range(0, 99);
        jx   = rand_axis();
        jy   = rand_axis();
        btn  = 8'($urandom);
        if (roll < 60) begin
            cmd = CMD_JOY;
        end else if (roll < 88) begin
            cmd = CMD_BUTTON;
            case ($urandom_range(0, 9))
                0, 1, 2: btn = BTN_REMOTE_ON;
                3:       btn = BTN_REMOTE_OFF;
                4, 5:    btn = BTN_NITRO_ON;
                6, 7:    btn = BTN_NITRO_OFF;
                default: ;
            endcase
        end else begin
            cmd = ($urandom_range(0, 1) == 1) ? CMD_OTHER : CMD_UNUSED;
        end
        offer_msg(cmd, jx, jy, btn, 1'b0, '0);
    endtask

    task automatic write_use_joystick(input logic value);
        while (wheels_pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        use_joystick = value;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    initial begin : result_sink
        int gap;
        t_wheel_cmd got, want;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                gap = idle_cycles();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            got.handled     = m_tuser[0];
            got.drive_valid = m_tuser[1];
            got.left_speed  = m_tdata[13:0];
            got.right_speed = m_tdata[27:14];
            if (wheels_pending.size() == 0) begin
                $error("result item arrived with no message outstanding");
                mismatches++;
            end else begin
                want = wheels_pending.pop_front();
                compare_field("handled", want.handled, got.handled);
                compare_field("drive_valid", want.drive_valid, got.drive_valid);
                compare_field("left_speed", want.left_speed, got.left_speed);
                compare_field("right_speed", want.right_speed, got.right_speed);
                compare_field("tdata padding", 0, m_tdata[31:28]);
            end
        end
    end

    initial begin : stimulus
        t_stim_row  directed_rows [25];
        t_phase     phases [5];
        t_wheel_cmd fixed_res;
        directed_rows = '{
            '{CMD_JOY, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 14'sd0, 14'sd0},
            '{CMD_JOY, 8'h00, 8'h7F, 8'h00, 1'b1, 1'b1, 1'b1, 14'sd4000, 14'sd4000},
            '{CMD_JOY, 8'h00, 8'h80, 8'h00, 1'b1, 1'b1, 1'b1, -14'sd4000, -14'sd4000},
            '{CMD_JOY, 8'h7F, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, 14'sd1000, -14'sd1000},
            '{CMD_JOY, 8'h80, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, -14'sd1000, 14'sd1000},
            '{CMD_JOY, 8'h7F, 8'h7F, 8'h00, 1'b1, 1'b1, 1'b1, 14'sd3000, 14'sd2000},
            '{CMD_JOY, 8'h80, 8'h80, 8'h00, 1'b1, 1'b1, 1'b1, -14'sd2000, -14'sd3000},
            '{CMD_JOY, 8'h04, 8'h04, 8'h00, 1'b1, 1'b1, 1'b1, 14'sd0, 14'sd0},
            '{CMD_JOY, 8'hFC, 8'hF2, 8'h00, 1'b1, 1'b1, 1'b1, 14'sd0, 14'sd0},
            '{CMD_JOY, 8'hFB, 8'hF1, 8'h00, 1'b0, 1'b0, 1'b0, 14'sd0, 14'sd0},
            '{CMD_JOY, 8'h05, 8'h05, 8'h00, 1'b0, 1'b0, 1'b0, 14'sd0, 14'sd0},
            '{CMD_BUTTON, 8'h00, 8'h00, BTN_NITRO_ON, 1'b1, 1'b1, 1'b0, 14'sd0, 14'sd0},
            '{CMD_JOY, 8'h7F, 8'h7F, 8'h00, 1'b1, 1'b1, 1'b1, 14'sd6000, 14'sd4000},
            '{CMD_JOY, 8'h00, 8'h7F, 8'h00, 1'b1, 1'b1, 1'b1, 14'sd6000, 14'sd6000},
            '{CMD_JOY, 8'h80, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1, -14'sd2000, 14'sd2000},
            '{CMD_BUTTON, 8'h00, 8'h00, BTN_NITRO_OFF, 1'b1, 1'b1, 1'b0, 14'sd0, 14'sd0},
            '{CMD_BUTTON, 8'h00, 8'h00, BTN_REMOTE_OFF, 1'b1, 1'b1, 1'b0, 14'sd0, 14'sd0},
            '{CMD_JOY, 8'h7F, 8'h7F, 8'h00, 1'b1, 1'b1, 1'b0, 14'sd0, 14'sd0},
            '{CMD_OTHER, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 14'sd0, 14'sd0},
            '{CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, 14'sd0, 14'sd0},
            '{CMD_BUTTON, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, 14'sd0, 14'sd0},
            '{CMD_BUTTON, 8'h00, 8'h00, BTN_REMOTE_ON, 1'b1, 1'b1, 1'b0, 14'sd0, 14'sd0},
            '{CMD_JOY, 8'h80, 8'h7F, 8'h00, 1'b0, 1'b0, 1'b0, 14'sd0, 14'sd0},
            '{CMD_JOY, 8'h7F, 8'h80, 8'h00, 1'b0, 1'b0, 1'b0, 14'sd0, 14'sd0},
            '{CMD_BUTTON, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 14'sd0, 14'sd0}
        };
        phases = '{
            '{1'b0, 200, 1'b0, 1'b0},
            '{1'b1, 300, 1'b1, 1'b1},
            '{1'b0, 150, 1'b0, 1'b0},
            '{1'b1, 400, 1'b0, 1'b0},
            '{1'b1, 150, 1'b1, 1'b0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            fixed_res.handled     = directed_rows[i].handled;
            fixed_res.drive_valid = directed_rows[i].drive_valid;
            fixed_res.left_speed  = directed_rows[i].left_speed;
            fixed_res.right_speed = directed_rows[i].right_speed;
            offer_msg(directed_rows[i].cmd, directed_rows[i].joy_x, directed_rows[i].joy_y,
                      directed_rows[i].button, directed_rows[i].fixed, fixed_res);
        end
        s_tvalid <= 1'b0;

        // The first quiet phase also parks the output long enough for the
        // internal queue to fill and push back on the input.
        foreach (phases[p]) begin
            write_use_joystick(phases[p].use_joy);
            no_idle      = phases[p].quiet;
            hold_request = phases[p].hold;
            repeat (phases[p].count) offer_random_msg();
            s_tvalid <= 1'b0;
        end

        while (wheels_pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("joystick_to_differential_drive verification clean");
        end else begin
            $display("joystick_to_differential_drive verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
src/jtdd_pkg.sv
src/jtdd_front.sv
src/jtdd_queue.sv
src/jtdd_back.sv
src/joystick_to_differential_drive.sv
src/jtdd_checker.sv
tb/joystick_to_differential_drive_test.sv
